[sv/wbf_pkg.sv]
`default_nettype none

package wbf_pkg;

    localparam int MAX_WORD_BYTES_DEF    = 16;
    localparam int NUM_BLOCKED_WORDS_DEF = 4;
    localparam int BLK_ROWS              = 16;
    localparam int BLK_COLS              = 16;
    localparam int ROW_W                 = $clog2(BLK_ROWS);
    localparam int COL_W                 = $clog2(BLK_COLS);
    localparam int BLK_LEN_W             = $clog2(BLK_COLS + 1);

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PERIOD    = 8'h2E;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUEST     = 8'h3F;
    localparam logic [7:0] CH_EXCL      = 8'h21;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WORD,
        ST_TAIL
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load_word;
        logic load_tail;
    } wbf_cmd_t;

    typedef struct packed {
        logic has_result;
        logic has_word;
        logic word_last;
        logic out_free;
    } wbf_sts_t;

    function automatic logic is_separator(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_PERIOD) || (b == CH_COMMA) ||
               (b == CH_SEMI) || (b == CH_COLON) || (b == CH_QUEST) ||
               (b == CH_EXCL);
    endfunction

    function automatic logic [BLK_LEN_W-1:0] blk_len(input logic [ROW_W-1:0] row);
        logic [BLK_LEN_W-1:0] len;
        unique case (row)
            4'd0:    len = BLK_LEN_W'(10);
            4'd1:    len = BLK_LEN_W'(10);
            4'd2:    len = BLK_LEN_W'(4);
            4'd3:    len = BLK_LEN_W'(5);
            default: len = '0;
        endcase
        return len;
    endfunction

    // first byte of each entry sits in the low bits
    function automatic logic [BLK_COLS*8-1:0] blk_row(input logic [ROW_W-1:0] row);
        logic [BLK_COLS*8-1:0] v;
        unique case (row)
            4'd0:    v = 128'h000000000000_82D1BED0B8D0B4D0B8D0;
            4'd1:    v = 128'h000000000000_BAD0B0D080D183D1B4D0;
            4'd2:    v = 128'h6B637566;
            4'd3:    v = 128'h746F696469;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] blk_byte(input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col);
        logic [BLK_COLS*8-1:0] v;
        v = blk_row(row);
        return v[col*8 +: 8];
    endfunction

endpackage

`default_nettype wire

[sv/wbf_ram.sv]
`default_nettype none

module wbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/wbf_ctrl.sv]
`default_nettype none

module wbf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output      logic             s_ready,
    input  wire wbf_pkg::wbf_sts_t sts,
    output      wbf_pkg::wbf_cmd_t cmd
);

    wbf_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wbf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wbf_pkg::ST_IDLE: begin
                if (s_valid && sts.has_result) begin
                    state_next = sts.has_word ? wbf_pkg::ST_READ : wbf_pkg::ST_TAIL;
                end
            end
            wbf_pkg::ST_READ: begin
                state_next = wbf_pkg::ST_WORD;
            end
            wbf_pkg::ST_WORD: begin
                if (sts.out_free) begin
                    state_next = sts.word_last ? wbf_pkg::ST_TAIL : wbf_pkg::ST_READ;
                end
            end
            wbf_pkg::ST_TAIL: begin
                if (sts.out_free) begin
                    state_next = wbf_pkg::ST_IDLE;
                end
            end
            default: state_next = wbf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.accept    = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.load_word = 1'b0;
        cmd.load_tail = 1'b0;
        unique case (state_reg)
            wbf_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            wbf_pkg::ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            wbf_pkg::ST_WORD: begin
                cmd.load_word = sts.out_free;
            end
            wbf_pkg::ST_TAIL: begin
                cmd.load_tail = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/wbf_datapath.sv]
`default_nettype none

module wbf_datapath #(
    parameter int MAX_WORD_BYTES    = wbf_pkg::MAX_WORD_BYTES_DEF,
    parameter int NUM_BLOCKED_WORDS = wbf_pkg::NUM_BLOCKED_WORDS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_is_line_break,
    input  wire wbf_pkg::wbf_cmd_t cmd,
    output      wbf_pkg::wbf_sts_t sts,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output      logic [7:0]        m_out_byte,
    output      logic              m_run_last
);

    localparam int AW = $clog2(MAX_WORD_BYTES);
    localparam int LW = $clog2(MAX_WORD_BYTES + 1);
    localparam int RW = wbf_pkg::ROW_W;
    localparam int CW = wbf_pkg::COL_W;

    logic [LW-1:0]                word_len_reg, word_len_next;
    logic                         pass_reg, pass_next;
    logic [NUM_BLOCKED_WORDS-1:0] match_reg, match_next, match_upd, len_hit;
    logic [LW-1:0]                emit_len_reg, emit_len_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [7:0]                   tail_reg, tail_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;

    logic       sep, blocked, word_full, emit_word, buf_write;
    logic [7:0] rd_data;

    // per-entry prefix match, updated as bytes are buffered
    always_comb begin
        for (int i = 0; i < NUM_BLOCKED_WORDS; i++) begin
            logic [wbf_pkg::BLK_LEN_W-1:0] len;
            len = wbf_pkg::blk_len(RW'(i));
            len_hit[i]   = (len != '0) && (8'(word_len_reg) == 8'(len));
            match_upd[i] = match_reg[i] && (8'(word_len_reg) < 8'(len)) &&
                           (s_data_byte == wbf_pkg::blk_byte(RW'(i), word_len_reg[CW-1:0]));
        end
    end

    assign sep       = wbf_pkg::is_separator(s_data_byte);
    assign blocked   = |(match_reg & len_hit);
    assign word_full = (word_len_reg == LW'(MAX_WORD_BYTES));
    assign emit_word = !pass_reg &&
                       (s_is_line_break ? !blocked : ((sep && !blocked) || (!sep && word_full)));
    assign buf_write = cmd.accept && !s_is_line_break && !pass_reg && !sep && !word_full;

    assign sts.has_result = s_is_line_break || pass_reg || (sep && !blocked) ||
                            (!sep && word_full);
    assign sts.has_word   = emit_word && (word_len_reg != '0);
    assign sts.word_last  = ((LW'(idx_reg) + LW'(1)) == emit_len_reg);
    assign sts.out_free   = !out_valid_reg || m_ready;

    wbf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD_BYTES)
    ) u_word_ram (
        .clk   (aclk),
        .we    (buf_write),
        .waddr (word_len_reg[AW-1:0]),
        .wdata (s_data_byte),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    always_comb begin
        word_len_next  = word_len_reg;
        pass_next      = pass_reg;
        match_next     = match_reg;
        emit_len_next  = emit_len_reg;
        idx_next       = idx_reg;
        tail_next      = tail_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (cmd.accept) begin
            emit_len_next = word_len_reg;
            idx_next      = '0;
            tail_next     = s_is_line_break ? wbf_pkg::NEWLINE_BYTE : s_data_byte;
            if (s_is_line_break) begin
                word_len_next = '0;
                pass_next     = 1'b0;
                match_next    = '1;
            end else if (pass_reg) begin
                if (sep) begin
                    pass_next = 1'b0;
                end
            end else if (sep) begin
                word_len_next = '0;
                match_next    = '1;
            end else if (!word_full) begin
                word_len_next = word_len_reg + LW'(1);
                match_next    = match_upd;
            end else begin
                // overlong word streams through from here on
                word_len_next = '0;
                pass_next     = 1'b1;
                match_next    = '1;
            end
        end

        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_word) begin
            idx_next       = idx_reg + AW'(1);
            out_valid_next = 1'b1;
            out_byte_next  = rd_data;
            out_last_next  = 1'b0;
        end else if (cmd.load_tail) begin
            out_valid_next = 1'b1;
            out_byte_next  = tail_reg;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_len_reg  <= '0;
            pass_reg      <= 1'b0;
            match_reg     <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            word_len_reg  <= word_len_next;
            pass_reg      <= pass_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        emit_len_reg <= emit_len_next;
        idx_reg      <= idx_next;
        tail_reg     <= tail_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_run_last = out_last_reg;

endmodule

`default_nettype wire

[sv/word_blocklist_filter.sv]
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------
// s_       | in        | s_valid / s_ready  | s_data_byte, s_is_line_break
// m_       | out       | m_valid / m_ready  | m_out_byte, m_run_last
//
// a byte that is only buffered leaves the sequencer idle; an item that releases
// a word steps through ST_READ and ST_WORD for each byte, for the registered
// read port of the word buffer, then ST_TAIL for the separator or newline byte.
// reset is synchronous and active low; the word buffer needs no clearing.
// a stalled m_ready holds the output register and the sequencer; s_ready is
// high whenever the sequencer is idle, also while a last byte waits.
`default_nettype none

module word_blocklist_filter #(
    parameter int MAX_WORD_BYTES    = wbf_pkg::MAX_WORD_BYTES_DEF,
    parameter int NUM_BLOCKED_WORDS = wbf_pkg::NUM_BLOCKED_WORDS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output      logic       s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_is_line_break,
    output      logic       m_valid,
    input  wire logic       m_ready,
    output      logic [7:0] m_out_byte,
    output      logic       m_run_last
);

    wbf_pkg::wbf_cmd_t cmd;
    wbf_pkg::wbf_sts_t sts;

    wbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wbf_datapath #(
        .MAX_WORD_BYTES    (MAX_WORD_BYTES),
        .NUM_BLOCKED_WORDS (NUM_BLOCKED_WORDS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data_byte     (s_data_byte),
        .s_is_line_break (s_is_line_break),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_run_last      (m_run_last)
    );

endmodule

`default_nettype wire

[sv/wbf_checker.sv]
`default_nettype none

module wbf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_data_byte,
    input wire logic       s_is_line_break,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_run_last
);

    // a waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data_byte) && $stable(s_is_line_break))
        else $error("waiting input transfer changed");

    // output side holds a stalled transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("stalled output transfer changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // a line break always produces at least a newline, so the block is busy
    a_lb_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_is_line_break |=> !s_ready)
        else $error("input taken right after a line break");

    // mid-word bytes mean the item is still being worked on
    a_mid_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |-> !s_ready)
        else $error("input ready while a result run is open");

endmodule

bind word_blocklist_filter wbf_checker u_wbf_checker (.*);

`default_nettype wire
